// ===== rtl/rbcs_pkg.sv =====
`timescale 1ns / 1ps
package rbcs_pkg;

    // action codes
    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_REJ  = 2'd2;
    localparam logic [1:0] ST_BUSY = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TOTAL   = 2'd0;
    localparam logic [1:0] CFG_SLOTS   = 2'd1;
    localparam logic [1:0] CFG_STREAMS = 2'd2;
    localparam logic [1:0] CFG_BBYTES  = 2'd3;

    localparam logic [7:0] NOT_CACHED  = 8'hFF;
    localparam logic [7:0] EMERG_DEPTH = 8'd2;

    // compare width for block numbers and pointer sums
    localparam int CW = 17;

    // datapath operations
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_CLR     = 5'd1;
    localparam logic [4:0] OP_LOAD    = 5'd2;
    localparam logic [4:0] OP_DISP    = 5'd3;
    localparam logic [4:0] OP_LK_RD   = 5'd4;
    localparam logic [4:0] OP_LK_MUL  = 5'd5;
    localparam logic [4:0] OP_LK_ADD  = 5'd6;
    localparam logic [4:0] OP_COMMIT  = 5'd7;
    localparam logic [4:0] OP_DEM_RD  = 5'd8;
    localparam logic [4:0] OP_DEM_CHK = 5'd9;
    localparam logic [4:0] OP_VMOD    = 5'd10;
    localparam logic [4:0] OP_VSLOT   = 5'd11;
    localparam logic [4:0] OP_VSTR    = 5'd12;
    localparam logic [4:0] OP_VEND    = 5'd13;
    localparam logic [4:0] OP_CINIT   = 5'd14;
    localparam logic [4:0] OP_CRD     = 5'd15;
    localparam logic [4:0] OP_CSTORE  = 5'd16;
    localparam logic [4:0] OP_CCHK    = 5'd17;
    localparam logic [4:0] OP_PICK    = 5'd18;
    localparam logic [4:0] OP_FSEL    = 5'd19;
    localparam logic [4:0] OP_FCHK    = 5'd20;
    localparam logic [4:0] OP_EVICT   = 5'd21;
    localparam logic [4:0] OP_PUSH    = 5'd22;

    typedef struct packed {
        logic [4:0] op;
        logic       in_take;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] act;
        logic       disp_done;
        logic       x_ge;
        logic       slot_invalid;
        logic       s_last;
        logic       least_far;
        logic       i_last;
        logic       cnt_go;
        logic       out_free;
    } t_stat;

endpackage

// ===== rtl/readahead_block_cache_scheduler.sv =====
`timescale 1ns / 1ps
// tick: unless I/O is busy, commits the pending fill, scans the slots for a victim,
//   counts the cached run of each stream in use, then picks the block to fetch
// throughput: one item at a time, the next accepted once its result is pushed out
// reset: synchronous active low; a clearing pass marks every block uncached, input
//   held off until it ends
module readahead_block_cache_scheduler
    import rbcs_pkg::*;
#(
    parameter int MAX_SLOTS   = 255,
    parameter int MAX_STREAMS = 8,
    parameter int MAX_BLOCKS  = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    // item in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_stream,
    input  logic        i_stream_open,
    input  logic [13:0] i_block_index,
    input  logic [7:0]  i_readahead,
    input  logic [15:0] i_start_offset,
    input  logic [15:0] i_byte_count,
    input  logic        i_blocking,
    input  logic        i_io_busy,
    // item out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_hit_slot,
    output logic [23:0] o_byte_address,
    output logic [15:0] o_bytes_granted,
    output logic        o_issue_fill,
    output logic [13:0] o_fill_block,
    output logic [7:0]  o_fill_slot,
    output logic        o_urgent
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one state per step of lookup, commit, victim scan, run count, pick
    rbcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // maps, stream table, scan registers and the output register
    rbcs_dp #(
        .MAX_SLOTS   (MAX_SLOTS),
        .MAX_STREAMS (MAX_STREAMS),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_stream        (i_stream),
        .i_stream_open   (i_stream_open),
        .i_block_index   (i_block_index),
        .i_readahead     (i_readahead),
        .i_start_offset  (i_start_offset),
        .i_byte_count    (i_byte_count),
        .i_blocking      (i_blocking),
        .i_io_busy       (i_io_busy),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_hit_slot      (o_hit_slot),
        .o_byte_address  (o_byte_address),
        .o_bytes_granted (o_bytes_granted),
        .o_issue_fill    (o_issue_fill),
        .o_fill_block    (o_fill_block),
        .o_fill_slot     (o_fill_slot),
        .o_urgent        (o_urgent)
    );

endmodule

// ===== rtl/rbcs_ctrl.sv =====
`timescale 1ns / 1ps
module rbcs_ctrl
    import rbcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_LRD    = 5'd3;
    localparam logic [4:0] S_LMUL   = 5'd4;
    localparam logic [4:0] S_LADD   = 5'd5;
    localparam logic [4:0] S_COMMIT = 5'd6;
    localparam logic [4:0] S_DRD    = 5'd7;
    localparam logic [4:0] S_DCHK   = 5'd8;
    localparam logic [4:0] S_VMOD   = 5'd9;
    localparam logic [4:0] S_VSLOT  = 5'd10;
    localparam logic [4:0] S_VSTR   = 5'd11;
    localparam logic [4:0] S_VEND   = 5'd12;
    localparam logic [4:0] S_CINIT  = 5'd13;
    localparam logic [4:0] S_CRD    = 5'd14;
    localparam logic [4:0] S_CCHK   = 5'd15;
    localparam logic [4:0] S_PICK   = 5'd16;
    localparam logic [4:0] S_FSEL   = 5'd17;
    localparam logic [4:0] S_FCHK   = 5'd18;
    localparam logic [4:0] S_EVICT  = 5'd19;
    localparam logic [4:0] S_OUT    = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.in_take = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op      = OP_LOAD;
                    o_cmd.in_take = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.op = OP_DISP;
                if (i_stat.disp_done) n_state = S_OUT;
                else if (i_stat.act == ACT_LOOKUP) n_state = S_LRD;
                else n_state = S_COMMIT;
            end
            S_LRD: begin
                o_cmd.op = OP_LK_RD;
                n_state  = S_LMUL;
            end
            S_LMUL: begin
                o_cmd.op = OP_LK_MUL;
                n_state  = S_LADD;
            end
            S_LADD: begin
                o_cmd.op = OP_LK_ADD;
                n_state  = S_OUT;
            end
            S_COMMIT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_DRD;
            end
            S_DRD: begin
                o_cmd.op = OP_DEM_RD;
                n_state  = S_DCHK;
            end
            S_DCHK: begin
                o_cmd.op = OP_DEM_CHK;
                n_state  = S_VMOD;
            end
            S_VMOD: begin
                if (i_stat.x_ge) o_cmd.op = OP_VMOD;
                else n_state = S_VSLOT;
            end
            S_VSLOT: begin
                o_cmd.op = OP_VSLOT;
                n_state  = i_stat.slot_invalid ? S_CINIT : S_VSTR;
            end
            S_VSTR: begin
                o_cmd.op = OP_VSTR;
                if (i_stat.s_last) n_state = S_VEND;
            end
            S_VEND: begin
                o_cmd.op = OP_VEND;
                n_state  = (i_stat.least_far || i_stat.i_last) ? S_CINIT : S_VSLOT;
            end
            S_CINIT: begin
                o_cmd.op = OP_CINIT;
                n_state  = S_CRD;
            end
            S_CRD: begin
                if (i_stat.cnt_go) begin
                    o_cmd.op = OP_CRD;
                    n_state  = S_CCHK;
                end else begin
                    o_cmd.op = OP_CSTORE;
                    n_state  = i_stat.s_last ? S_PICK : S_CINIT;
                end
            end
            S_CCHK: begin
                o_cmd.op = OP_CCHK;
                n_state  = S_CRD;
            end
            S_PICK: begin
                o_cmd.op = OP_PICK;
                if (i_stat.s_last) n_state = S_FSEL;
            end
            S_FSEL: begin
                o_cmd.op = OP_FSEL;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                o_cmd.op = OP_FCHK;
                n_state  = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.op = OP_EVICT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else r_state <= n_state;
    end

endmodule

// ===== rtl/rbcs_dp.sv =====
`timescale 1ns / 1ps
module rbcs_dp
    import rbcs_pkg::*;
#(
    parameter int MAX_SLOTS   = 255,
    parameter int MAX_STREAMS = 8,
    parameter int MAX_BLOCKS  = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_stream,
    input  logic        i_stream_open,
    input  logic [13:0] i_block_index,
    input  logic [7:0]  i_readahead,
    input  logic [15:0] i_start_offset,
    input  logic [15:0] i_byte_count,
    input  logic        i_blocking,
    input  logic        i_io_busy,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_hit_slot,
    output logic [23:0] o_byte_address,
    output logic [15:0] o_bytes_granted,
    output logic        o_issue_fill,
    output logic [13:0] o_fill_block,
    output logic [7:0]  o_fill_slot,
    output logic        o_urgent
);

    localparam int BW     = $clog2(MAX_BLOCKS);
    localparam int SLI    = $clog2(MAX_SLOTS);
    localparam int SSW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int SCW    = SSW + 1;
    localparam int EW     = CW + 1;
    localparam int TB_CAP = (MAX_BLOCKS > 32767) ? 32767 : MAX_BLOCKS;
    localparam int TB_RST = (MAX_BLOCKS > 16384) ? 16384 : MAX_BLOCKS;
    localparam int SN_RST = (MAX_STREAMS > 8) ? 8 : MAX_STREAMS;

    // configuration
    logic [14:0] r_total;
    logic [7:0]  r_slots;
    logic [3:0]  r_streams;
    logic [16:0] r_bb;
    logic [14:0] n_total;
    logic [7:0]  n_slots;
    logic [3:0]  n_streams;
    logic [16:0] n_bb;

    // captured item
    logic [1:0]  r_act;
    logic [2:0]  r_str;
    logic        r_open;
    logic [13:0] r_blk;
    logic [7:0]  r_ra;
    logic [15:0] r_start;
    logic [15:0] r_cnt;
    logic        r_blocking;
    logic        r_busy;

    // stream table
    logic        r_sopen  [MAX_STREAMS];
    logic [13:0] r_sptr   [MAX_STREAMS];
    logic [7:0]  r_sdep   [MAX_STREAMS];
    logic [7:0]  r_savail [MAX_STREAMS];

    // slot map
    logic [MAX_SLOTS-1:0] r_ovalid;
    logic [BW-1:0]        mem_owner [MAX_SLOTS];
    logic [BW-1:0]        r_owner_q;
    logic                 own_we;
    logic                 own_re;
    logic [SLI-1:0]       own_wa;
    logic [SLI-1:0]       own_ra;

    // block map
    logic [7:0]    mem_home [MAX_BLOCKS];
    logic [7:0]    r_home_q;
    logic          home_we;
    logic          home_re;
    logic [BW-1:0] home_wa;
    logic [BW-1:0] home_ra;
    logic [7:0]    home_wd;
    logic [BW-1:0] r_clr;

    // demand and pending fill
    logic          r_dvalid;
    logic [13:0]   r_dreq;
    logic          r_pvalid;
    logic [BW-1:0] r_pblk;
    logic [7:0]    r_pslot;
    logic [7:0]    r_vstart;

    // lookup
    logic        r_hit;
    logic [24:0] r_prod;
    logic [16:0] sum_span;
    logic [15:0] grant;

    // victim scan
    logic [7:0]           r_x;
    logic [7:0]           r_i;
    logic [7:0]           r_victim;
    logic signed [EW-1:0] r_best;
    logic signed [EW-1:0] r_least;
    logic                 r_lfar;
    logic [CW-1:0]        own_c;
    logic [CW-1:0]        ptr_c;
    logic [CW-1:0]        pd_c;
    logic signed [EW-1:0] ext;
    logic                 ext_on;

    // stream loop, run count, picks
    logic [SCW-1:0] r_s;
    logic [SSW-1:0] si;
    logic [4:0]     s_inc;
    logic           s_live;
    logic [14:0]    r_p;
    logic [14:0]    r_lim;
    logic           r_cstop;
    logic [14:0]    ps_lim;
    logic [14:0]    pa;
    logic           pk_base;
    logic [7:0]     elim;
    logic           e_take;
    logic           n_take;
    logic           r_ev;
    logic [SSW-1:0] r_eidx;
    logic [7:0]     r_eav;
    logic           r_nv;
    logic [SSW-1:0] r_nidx;
    logic [7:0]     r_nav;
    logic [14:0]    fetch_n;
    logic           want_n;
    logic           urg_n;
    logic [14:0]    r_fetch;
    logic           r_want;
    logic           r_urg;

    // staged result
    logic [1:0]  r_rs_status;
    logic [7:0]  r_rs_slot;
    logic [23:0] r_rs_addr;
    logic [15:0] r_rs_grant;
    logic        r_rs_issue;
    logic [13:0] r_rs_fblk;
    logic [7:0]  r_rs_fslot;
    logic        r_rs_urg;

    logic r_o_valid;
    logic reject;

    assign si     = r_s[SSW-1:0];
    assign s_inc  = 5'(r_s) + 5'd1;
    // no stream counts when none are in use
    assign s_live = (5'(r_s) < 5'(r_streams));

    // configuration saturation
    always_comb begin
        n_total   = (i_cfg_data[14:0] > 15'(TB_CAP)) ? 15'(TB_CAP) : i_cfg_data[14:0];
        n_slots   = (i_cfg_data[7:0] < 8'd2) ? 8'd2 :
                    ((i_cfg_data[7:0] > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : i_cfg_data[7:0]);
        n_streams = ({1'b0, i_cfg_data[3:0]} > 5'(MAX_STREAMS)) ? 4'(MAX_STREAMS)
                    : i_cfg_data[3:0];
        n_bb      = (i_cfg_data == 17'd0) ? 17'd1 :
                    ((i_cfg_data > 17'd65536) ? 17'd65536 : i_cfg_data);
    end

    // lookup span
    assign sum_span = {1'b0, r_start} + {1'b0, r_cnt};
    assign grant    = (sum_span > r_bb) ? 16'(r_bb - {1'b0, r_start}) : r_cnt;
    assign reject   = ({1'b0, r_blk} >= r_total) || ({1'b0, r_start} >= r_bb);

    // extraneity of the current slot against stream si
    assign own_c  = CW'(r_owner_q);
    assign ptr_c  = CW'(r_sptr[si]);
    assign pd_c   = ptr_c + CW'(r_sdep[si]);
    assign ext    = $signed({1'b0, own_c}) - $signed({1'b0, pd_c});
    assign ext_on = s_live && r_sopen[si] && (own_c >= ptr_c);

    // run limit for stream si
    always_comb begin
        ps_lim = {1'b0, r_sptr[si]} + {7'd0, r_slots};
        if (ps_lim > r_total) ps_lim = r_total;
    end

    // pick candidates for stream si
    always_comb begin
        pa      = {1'b0, r_sptr[si]} + {7'd0, r_savail[si]};
        pk_base = s_live && r_sopen[si] && (r_sdep[si] != 8'd0) && (pa < r_total);
        elim    = (r_sdep[si] > EMERG_DEPTH) ? EMERG_DEPTH : r_sdep[si];
        e_take  = pk_base && (r_savail[si] < elim) && (!r_ev || r_savail[si] < r_eav);
        n_take  = pk_base && (r_savail[si] < r_sdep[si]) && (!r_nv || r_savail[si] < r_nav);
    end

    // fetch choice: emergency, then demand, then readahead
    always_comb begin
        fetch_n = 15'd0;
        want_n  = 1'b0;
        urg_n   = 1'b0;
        if (r_ev) begin
            fetch_n = {1'b0, r_sptr[r_eidx]} + {7'd0, r_eav};
            want_n  = 1'b1;
            urg_n   = 1'b1;
        end else if (r_dvalid) begin
            fetch_n = {1'b0, r_dreq};
            want_n  = 1'b1;
            urg_n   = 1'b1;
        end else if (r_nv) begin
            fetch_n = {1'b0, r_sptr[r_nidx]} + {7'd0, r_nav};
            want_n  = 1'b1;
        end
    end

    // memory port steering
    always_comb begin
        home_we = 1'b0;
        home_wa = r_clr;
        home_wd = NOT_CACHED;
        home_re = 1'b0;
        home_ra = BW'(r_blk);
        own_we  = 1'b0;
        own_wa  = SLI'(r_pslot);
        own_re  = 1'b0;
        own_ra  = SLI'(r_x);
        unique case (i_cmd.op)
            OP_CLR: home_we = 1'b1;
            OP_LK_RD: home_re = 1'b1;
            OP_COMMIT: begin
                home_we = r_pvalid;
                home_wa = r_pblk;
                home_wd = r_pslot;
                own_we  = r_pvalid;
            end
            OP_DEM_RD: begin
                home_re = 1'b1;
                home_ra = BW'(r_dreq);
            end
            OP_VSLOT: own_re = 1'b1;
            OP_CRD: begin
                home_re = 1'b1;
                home_ra = BW'(r_p);
            end
            OP_FSEL: begin
                home_re = 1'b1;
                home_ra = BW'(fetch_n);
            end
            OP_FCHK: begin
                own_re = 1'b1;
                own_ra = SLI'(r_victim);
            end
            OP_EVICT: begin
                home_we = r_want && r_ovalid[SLI'(r_victim)];
                home_wa = r_owner_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (home_we) mem_home[home_wa] <= home_wd;
        if (home_re) r_home_q <= mem_home[home_ra];
    end

    always_ff @(posedge i_clk) begin
        if (own_we) mem_owner[own_wa] <= r_pblk;
        if (own_re) r_owner_q <= mem_owner[own_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= 15'(TB_RST);
            r_slots   <= 8'(MAX_SLOTS);
            r_streams <= 4'(SN_RST);
            r_bb      <= 17'd16384;
            r_ovalid  <= '0;
            r_dvalid  <= 1'b0;
            r_pvalid  <= 1'b0;
            r_vstart  <= 8'd0;
            r_o_valid <= 1'b0;
            r_clr     <= '0;
            for (int k = 0; k < MAX_STREAMS; k++) begin
                r_sopen[k] <= 1'b0;
                r_sptr[k]  <= 14'd0;
                r_sdep[k]  <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOTAL:   r_total   <= n_total;
                    CFG_SLOTS:   r_slots   <= n_slots;
                    CFG_STREAMS: r_streams <= n_streams;
                    CFG_BBYTES:  r_bb      <= n_bb;
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_PUSH) r_o_valid <= 1'b1;
            else if (r_o_valid && !i_stall) r_o_valid <= 1'b0;
            unique case (i_cmd.op)
                OP_CLR: r_clr <= r_clr + BW'(1);
                OP_DISP: begin
                    if (r_act == ACT_SET && {2'b0, r_str} < {1'b0, r_streams}) begin
                        r_sopen[SSW'(r_str)] <= r_open;
                        r_sptr[SSW'(r_str)]  <= r_open ? r_blk : 14'd0;
                        r_sdep[SSW'(r_str)]  <= r_ra;
                    end
                end
                OP_LK_MUL: begin
                    if (!(r_home_q < r_slots) && r_blocking) begin
                        r_dvalid <= 1'b1;
                        r_dreq   <= r_blk;
                    end
                end
                OP_COMMIT: begin
                    if (r_pvalid) begin
                        r_ovalid[SLI'(r_pslot)] <= 1'b1;
                        r_pvalid                <= 1'b0;
                    end
                    if (r_dvalid && {1'b0, r_dreq} >= r_total) r_dreq <= 14'd0;
                end
                OP_DEM_CHK: begin
                    if (r_dvalid && r_home_q < r_slots) r_dvalid <= 1'b0;
                end
                OP_CSTORE: begin
                    r_savail[si] <= r_sopen[si] ? 8'(r_p - {1'b0, r_sptr[si]}) : 8'd0;
                end
                OP_EVICT: begin
                    if (r_want) begin
                        r_ovalid[SLI'(r_victim)] <= 1'b0;
                        r_vstart <= (r_victim + 8'd1 == r_slots) ? 8'd0 : r_victim + 8'd1;
                        r_pvalid <= 1'b1;
                        r_pblk   <= BW'(r_fetch);
                        r_pslot  <= r_victim;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_act      <= i_action;
                r_str      <= i_stream;
                r_open     <= i_stream_open;
                r_blk      <= i_block_index;
                r_ra       <= i_readahead;
                r_start    <= i_start_offset;
                r_cnt      <= i_byte_count;
                r_blocking <= i_blocking;
                r_busy     <= i_io_busy;
            end
            OP_DISP: begin
                r_rs_status <= ST_DONE;
                r_rs_slot   <= 8'd0;
                r_rs_addr   <= 24'd0;
                r_rs_grant  <= 16'd0;
                r_rs_issue  <= 1'b0;
                r_rs_fblk   <= 14'd0;
                r_rs_fslot  <= 8'd0;
                r_rs_urg    <= 1'b0;
                priority if (r_act == ACT_LOOKUP && reject) r_rs_status <= ST_REJ;
                else if (r_act == ACT_TICK && r_busy) r_rs_status <= ST_BUSY;
                else if (r_act != ACT_SET && r_act != ACT_LOOKUP && r_act != ACT_TICK)
                    r_rs_status <= ST_REJ;
            end
            OP_LK_MUL: begin
                r_hit  <= r_home_q < r_slots;
                r_prod <= {17'd0, r_home_q} * {8'd0, r_bb};
            end
            OP_LK_ADD: begin
                if (r_hit) begin
                    r_rs_slot  <= r_home_q;
                    r_rs_addr  <= 24'(r_prod + {9'd0, r_start});
                    r_rs_grant <= grant;
                end else begin
                    r_rs_status <= ST_MISS;
                end
            end
            OP_DEM_CHK: begin
                r_x      <= r_vstart;
                r_i      <= 8'd0;
                r_victim <= 8'd0;
                r_best   <= '0;
                r_s      <= '0;
                r_ev     <= 1'b0;
                r_nv     <= 1'b0;
            end
            OP_VMOD: r_x <= r_x - r_slots;
            OP_VSLOT: begin
                if (!r_ovalid[SLI'(r_x)]) r_victim <= r_x;
                r_least <= '0;
                r_lfar  <= 1'b1;
            end
            OP_VSTR: begin
                if (ext_on && (r_lfar || ext < r_least)) begin
                    r_least <= ext;
                    r_lfar  <= 1'b0;
                end
                r_s <= (s_inc == {1'b0, r_streams}) ? '0 : SCW'(s_inc);
            end
            OP_VEND: begin
                if (r_lfar) begin
                    r_victim <= r_x;
                end else if (r_least > r_best) begin
                    r_best   <= r_least;
                    r_victim <= r_x;
                end
                r_x <= (r_x + 8'd1 == r_slots) ? 8'd0 : r_x + 8'd1;
                r_i <= r_i + 8'd1;
            end
            OP_CINIT: begin
                r_p     <= {1'b0, r_sptr[si]};
                r_lim   <= ps_lim;
                r_cstop <= 1'b0;
            end
            OP_CSTORE: r_s <= (s_inc == {1'b0, r_streams}) ? '0 : SCW'(s_inc);
            OP_CCHK: begin
                if (r_home_q < r_slots) r_p <= r_p + 15'd1;
                else r_cstop <= 1'b1;
            end
            OP_PICK: begin
                if (e_take) begin
                    r_ev   <= 1'b1;
                    r_eidx <= si;
                    r_eav  <= r_savail[si];
                end
                if (n_take) begin
                    r_nv   <= 1'b1;
                    r_nidx <= si;
                    r_nav  <= r_savail[si];
                end
                r_s <= (s_inc == {1'b0, r_streams}) ? '0 : SCW'(s_inc);
            end
            OP_FSEL: begin
                r_fetch <= fetch_n;
                r_want  <= want_n;
                r_urg   <= urg_n;
            end
            OP_FCHK: begin
                if (r_fetch >= r_total || r_home_q < r_slots) r_want <= 1'b0;
            end
            OP_EVICT: begin
                if (r_want) begin
                    r_rs_issue <= 1'b1;
                    r_rs_fblk  <= r_fetch[13:0];
                    r_rs_fslot <= r_victim;
                    r_rs_urg   <= r_urg;
                end
            end
            OP_PUSH: begin
                o_status        <= r_rs_status;
                o_hit_slot      <= r_rs_slot;
                o_byte_address  <= r_rs_addr;
                o_bytes_granted <= r_rs_grant;
                o_issue_fill    <= r_rs_issue;
                o_fill_block    <= r_rs_fblk;
                o_fill_slot     <= r_rs_fslot;
                o_urgent        <= r_rs_urg;
            end
            default: ;
        endcase
    end

    assign o_valid = r_o_valid;

    // status to the controller
    always_comb begin
        o_stat.clr_last     = (r_clr == BW'(MAX_BLOCKS - 1));
        o_stat.act          = r_act;
        o_stat.disp_done    = (r_act == ACT_SET) || (r_act == ACT_LOOKUP && reject) ||
                              (r_act == ACT_TICK && r_busy) ||
                              (r_act != ACT_SET && r_act != ACT_LOOKUP && r_act != ACT_TICK);
        o_stat.x_ge         = (r_x >= r_slots);
        o_stat.slot_invalid = !r_ovalid[SLI'(r_x)];
        o_stat.s_last       = (s_inc == {1'b0, r_streams}) || !s_live;
        o_stat.least_far    = r_lfar;
        o_stat.i_last       = (r_i + 8'd1 == r_slots);
        o_stat.cnt_go       = s_live && r_sopen[si] && (r_p < r_lim) && !r_cstop;
        o_stat.out_free     = !r_o_valid || !i_stall;
    end

endmodule
